### rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros shared by the RTL of the frame receiver.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/cfr_pkg.sv
// cfr_pkg: item types, event codes and register map of the frame receiver.
// Depends on nothing; used by command_frame_receiver.
package cfr_pkg;

    // event reported with every item
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_OK        = 3'd1,
        EV_BAD_TAIL  = 3'd2,
        EV_BAD_CHECK = 3'd3,
        EV_BAD_CMD   = 3'd4
    } t_event;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_COMMAND = 3'd4;

    // register reset values
    localparam logic [7:0] RST_HEADER_FIRST  = 8'd171;
    localparam logic [7:0] RST_HEADER_SECOND = 8'd205;
    localparam logic [7:0] RST_TAIL_FIRST    = 8'd0;
    localparam logic [7:0] RST_TAIL_SECOND   = 8'd0;
    localparam logic [7:0] RST_POWER_COMMAND = 8'd0;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] source_port;
        t_event     event_res;
        logic       power_enable;
    } t_out_item;

endpackage

### rtl/core/cfr_ram.sv
// cfr_ram: generic single-clock RAM, one write and one registered read port.
// Depends on nothing; read returns the old data when it meets a write.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/command_frame_receiver.sv
// command_frame_receiver: per-port command frame parser with shared power enable.
// Depends on cfr_pkg, cfr_ram and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | in        | i_in_valid/o_in_ready  | i_in_item  (port, byte)
//  out     | out       | o_out_valid/i_out_ready| o_out_item (port, event, power)
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; each item taken is held in
// stage 1 for its per-port record read, then updated into the output register.
// A byte on the same port in the very next cycle gets the record by forwarding.
// Reset clears per-port valid flags, so every port starts hunting for a header.
// A stalled output stops the update stage and, behind it, the input.
`include "assert_macros.svh"

module command_frame_receiver #(
    parameter int FRAME_LEN = 8,
    parameter int CMD_POS   = 2,
    parameter int CTRL_POS  = 3,
    parameter int CHECK_POS = 4,
    parameter int PORTS     = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cfr_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cfr_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    localparam int PW = $clog2(FRAME_LEN);
    localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;
    // record: position, command byte, first tail byte, ctrl nonzero, check nonzero
    localparam int RW = PW + 18;
    localparam logic [3:0] PORTS_W = 4'(PORTS);

    // configuration registers
    logic [7:0] r_hdr1, r_hdr2, r_tail1, r_tail2, r_pcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1  <= cfr_pkg::RST_HEADER_FIRST;
            r_hdr2  <= cfr_pkg::RST_HEADER_SECOND;
            r_tail1 <= cfr_pkg::RST_TAIL_FIRST;
            r_tail2 <= cfr_pkg::RST_TAIL_SECOND;
            r_pcmd  <= cfr_pkg::RST_POWER_COMMAND;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cfr_pkg::CFG_HEADER_FIRST:  r_hdr1  <= i_cfg_data;
                cfr_pkg::CFG_HEADER_SECOND: r_hdr2  <= i_cfg_data;
                cfr_pkg::CFG_TAIL_FIRST:    r_tail1 <= i_cfg_data;
                cfr_pkg::CFG_TAIL_SECOND:   r_tail2 <= i_cfg_data;
                cfr_pkg::CFG_POWER_COMMAND: r_pcmd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic              r_s1_vld, r_out_vld;
    logic              s1_move, in_acc, ram_we;
    cfr_pkg::t_in_item r_s1_item;
    logic              r_s1_rng, r_s1_init, r_hit;
    logic [RW-1:0]     r_hit_rec, rd_rec, n_rec;
    logic [AW-1:0]     in_addr, s1_addr;
    logic [PORTS-1:0]  r_init;
    cfr_pkg::t_out_item r_out;
    logic              r_pwr, n_pwr;
    cfr_pkg::t_event   n_ev;

    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_addr    = AW'(i_in_item.port);
    assign s1_addr    = AW'(r_s1_item.port);
    assign ram_we     = s1_move && r_s1_rng;

    // per-port record store
    cfr_ram #(.WIDTH(RW), .DEPTH(PORTS)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s1_addr),
        .i_wdata (n_rec),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (rd_rec)
    );

    // stage 1 capture, with forwarding of a write that lands with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
            r_s1_rng  <= 4'(i_in_item.port) < PORTS_W;
            r_s1_init <= r_init[in_addr];
            r_hit     <= ram_we && (s1_addr == in_addr);
            r_hit_rec <= n_rec;
        end
    end

    // record valid flags: an unwritten port reads as position zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (ram_we) begin
            r_init[s1_addr] <= 1'b1;
        end
    end

    // frame update and judgement
    always_comb begin
        logic [RW-1:0] cur;
        logic [PW-1:0] pos, n_pos;
        logic [7:0]    c, cmd, tl1;
        logic          ctrl_nz, chk_nz;
        cur     = r_hit ? r_hit_rec : (r_s1_init ? rd_rec : '0);
        pos     = cur[RW-1 -: PW];
        cmd     = cur[17:10];
        tl1     = cur[9:2];
        ctrl_nz = cur[1];
        chk_nz  = cur[0];
        c       = r_s1_item.data_byte;
        n_pos   = pos;
        n_ev    = cfr_pkg::EV_NONE;
        n_pwr   = r_pwr;
        if (pos == '0) begin
            // hunting for the first header byte; flags start clear
            cmd     = '0;
            tl1     = '0;
            ctrl_nz = 1'b0;
            chk_nz  = 1'b0;
            if (c == r_hdr1) begin
                n_pos = PW'(1);
            end
        end else if (pos == PW'(1)) begin
            if (c == r_hdr2) begin
                n_pos = PW'(2);
            end else if (c != r_hdr1) begin
                n_pos = '0;
            end
        end else begin
            // body byte: keep only what the judgement needs
            if (32'(pos) == CMD_POS) begin
                cmd = c;
            end
            if (32'(pos) == FRAME_LEN - 2) begin
                tl1 = c;
            end
            if (32'(pos) == CTRL_POS) begin
                ctrl_nz = (c != '0);
            end
            if (32'(pos) == CHECK_POS || 32'(pos) == CHECK_POS + 1) begin
                chk_nz = chk_nz || (c != '0);
            end
            if (32'(pos) == FRAME_LEN - 1) begin
                n_pos = '0;
                priority if (tl1 != r_tail1 || c != r_tail2) begin
                    n_ev = cfr_pkg::EV_BAD_TAIL;
                end else if (chk_nz) begin
                    n_ev = cfr_pkg::EV_BAD_CHECK;
                end else if (cmd != r_pcmd) begin
                    n_ev = cfr_pkg::EV_BAD_CMD;
                end else begin
                    n_ev  = cfr_pkg::EV_OK;
                    n_pwr = ctrl_nz;
                end
            end else begin
                n_pos = pos + PW'(1);
            end
        end
        if (!r_s1_rng) begin
            n_ev  = cfr_pkg::EV_NONE;
            n_pwr = r_pwr;
        end
        n_rec = {n_pos, cmd, tl1, ctrl_nz, chk_nz};
    end

    // power level and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_move) begin
                r_pwr     <= n_pwr;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.source_port  <= r_s1_item.port;
            r_out.event_res    <= n_ev;
            r_out.power_enable <= n_pwr;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    `ASSERT_IMPLY(a_full_accept_moves, i_clk, i_rst_n, in_acc && r_s1_vld, s1_move)
    `ASSERT_IMPLY(a_write_in_range, i_clk, i_rst_n, ram_we, r_s1_rng && r_s1_vld)
    `ASSERT_NEXT(a_power_follows_ok, i_clk, i_rst_n, s1_move && (n_ev == cfr_pkg::EV_OK), r_pwr == $past(n_rec[1]))

endmodule
